[rtl/core/epr_pkg.sv]
package epr_pkg;

   // field widths
   localparam int OP_W    = 3;
   localparam int TIME_W  = 32;
   localparam int CAP_W   = 16;
   localparam int DIST_W  = 14;
   localparam int CFG_W   = 16;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;
   localparam int REG_IW  = 2;

   // measurement phases
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_RISE,
      PH_WAIT_FALL,
      PH_READY
   } phase_type;

   // operation codes
   localparam logic [OP_W-1:0] OP_START   = 3'd0;
   localparam logic [OP_W-1:0] OP_POLL    = 3'd1;
   localparam logic [OP_W-1:0] OP_CAPTURE = 3'd2;
   localparam logic [OP_W-1:0] OP_TAKE    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ    = 3'd4;

   // register indexes
   localparam logic [REG_IW-1:0] REG_TIMEOUT   = 2'd0;
   localparam logic [REG_IW-1:0] REG_MIN_PULSE = 2'd1;
   localparam logic [REG_IW-1:0] REG_MAX_PULSE = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd40;
   localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd116;
   localparam logic [CFG_W-1:0] MAX_PULSE_RST = 16'd26240;

   // distance arithmetic: mm = (w*343 + 1000) / 2000
   // the divide is split into a shift by 4 and a reciprocal multiply for 125
   localparam int SCALE_W     = 25;
   localparam int QUOT_IN_W   = SCALE_W - 4;
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 28;
   localparam logic [SCALE_W-1:0] SOUND_MUL = 25'd343;
   localparam logic [SCALE_W-1:0] ROUND_ADD = 25'd1000;
   localparam logic [RECIP_W-1:0] RECIP_K   = 22'd2147484;

   // register file contents
   typedef struct packed {
      logic [CFG_W-1:0] timeout_ms;
      logic [CFG_W-1:0] min_pulse_us;
      logic [CFG_W-1:0] max_pulse_us;
   } cfg_type;

   // result beat
   typedef struct packed {
      logic              accepted;
      logic              busy_res;
      logic              distance_valid;
      logic [DIST_W-1:0] range_mm;
      logic              timed_out;
   } rsp_type;

endpackage

[rtl/core/epr_if.sv]
interface epr_req_if import epr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [TIME_W-1:0] time_ms;
   logic [CAP_W-1:0]  capture_value;

   modport source (output valid, output op, output time_ms, output capture_value,
                   input ready);
   modport sink (input valid, input op, input time_ms, input capture_value,
                 output ready);
endinterface

interface epr_rsp_if import epr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic              busy_res;
   logic              distance_valid;
   logic [DIST_W-1:0] range_mm;
   logic              timed_out;

   modport source (output valid, output accepted, output busy_res,
                   output distance_valid, output range_mm, output timed_out,
                   input ready);
   modport sink (input valid, input accepted, input busy_res,
                 input distance_valid, input range_mm, input timed_out,
                 output ready);
endinterface

[rtl/core/epr_csr.sv]
module epr_csr import epr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type           cfg_ff;
   logic              wr_en;
   logic [REG_IW-1:0] reg_idx;

   // zero wait states
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_AW-1:2];

   // register writes, upper data bits dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms   <= TIMEOUT_RST;
         cfg_ff.min_pulse_us <= MIN_PULSE_RST;
         cfg_ff.max_pulse_us <= MAX_PULSE_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_TIMEOUT:   cfg_ff.timeout_ms   <= pwdata[CFG_W-1:0];
            REG_MIN_PULSE: cfg_ff.min_pulse_us <= pwdata[CFG_W-1:0];
            REG_MAX_PULSE: cfg_ff.max_pulse_us <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_TIMEOUT:   prdata = {{(CSR_DW-CFG_W){1'b0}}, cfg_ff.timeout_ms};
         REG_MIN_PULSE: prdata = {{(CSR_DW-CFG_W){1'b0}}, cfg_ff.min_pulse_us};
         REG_MAX_PULSE: prdata = {{(CSR_DW-CFG_W){1'b0}}, cfg_ff.max_pulse_us};
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/echo_pulse_range_meter.sv]
// Ultrasonic echo ranging sequencer.
// req_chan carries one command beat (start, poll, edge capture, take, read flag)
// with the current millisecond time and the latched microsecond capture value.
// rsp_chan returns exactly one result beat per command, in command order.
// csr_* is an APB-style port holding timeout_ms (0x0), min_pulse_us (0x4) and
// max_pulse_us (0x8); write only while no command is in flight.
// A command accepted on req_chan is held in the input register; it is processed
// once the result register is free or being taken, and its result is registered
// and presented on rsp_chan until the result beat is taken.
// Throughput: one command per cycle while results are taken. The phase machine
// and the capture path are updated in the same cycle the command is processed,
// so a following command sees the new state with no gap; the distance divide is
// one reciprocal multiply on 343*width + 1000, stored at the falling-edge capture.
// A stalled rsp_chan holds the result register; one more command waits in the
// input register, after which req_chan.ready drops until the result is taken.
// Reset returns the phase to idle, clears the timeout flag and restores the
// registers to 40 ms, 116 us and 26240 us.
module echo_pulse_range_meter import epr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   epr_req_if.sink           req_chan,
   epr_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   // input stage
   logic              stg_valid_ff;
   logic [OP_W-1:0]   stg_op_ff;
   logic [TIME_W-1:0] stg_time_ff;
   logic [CAP_W-1:0]  stg_cap_ff;

   // measurement state
   phase_type          phase_ff, phase_in;
   logic [CAP_W-1:0]   rise_time_ff, rise_time_in;
   logic [CAP_W-1:0]   pulse_width_ff, pulse_width_in;
   logic [SCALE_W-1:0] scaled_ff, scaled_in;
   logic [TIME_W-1:0]  start_time_ff, start_time_in;
   logic               timeout_flag_ff, timeout_flag_in;

   // result stage
   logic    out_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic advance;
   logic fire;
   logic [TIME_W-1:0]               elapsed;
   logic                            expired;
   logic [CAP_W-1:0]                width_new;
   logic                            in_range;
   logic [QUOT_IN_W+RECIP_W-1:0]    quot_prod;
   logic [DIST_W-1:0]               range_calc;

   epr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // handshake: result register free or being taken
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = stg_valid_ff && advance;
   assign req_chan.ready = !stg_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stg_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         stg_op_ff   <= req_chan.op;
         stg_time_ff <= req_chan.time_ms;
         stg_cap_ff  <= req_chan.capture_value;
      end
   end

   // timeout check, modulo 2^32 elapsed time
   assign elapsed = stg_time_ff - start_time_ff;
   assign expired = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.timeout_ms};

   // pulse width at the falling edge
   assign width_new = stg_cap_ff - rise_time_ff;

   // range check and distance from the stored product
   assign in_range   = (pulse_width_ff >= cfg.min_pulse_us) &&
                       (pulse_width_ff <= cfg.max_pulse_us);
   assign quot_prod  = scaled_ff[SCALE_W-1:4] * RECIP_K;
   assign range_calc = quot_prod[RECIP_SHIFT +: DIST_W];

   // next state and result
   always_comb begin
      phase_in        = phase_ff;
      rise_time_in    = rise_time_ff;
      pulse_width_in  = pulse_width_ff;
      scaled_in       = scaled_ff;
      start_time_in   = start_time_ff;
      timeout_flag_in = timeout_flag_ff;
      rsp_in          = '0;
      case (stg_op_ff)
         OP_START: begin
            if (phase_ff == PH_IDLE) begin
               timeout_flag_in = 1'b0;
               pulse_width_in  = '0;
               scaled_in       = ROUND_ADD;
               start_time_in   = stg_time_ff;
               phase_in        = PH_WAIT_RISE;
               rsp_in.accepted = 1'b1;
            end
         end
         OP_POLL: begin
            if ((phase_ff == PH_WAIT_RISE || phase_ff == PH_WAIT_FALL) && expired) begin
               phase_in        = PH_IDLE;
               timeout_flag_in = 1'b1;
            end
         end
         OP_CAPTURE: begin
            if (phase_ff == PH_WAIT_RISE) begin
               rise_time_in = stg_cap_ff;
               phase_in     = PH_WAIT_FALL;
            end else if (phase_ff == PH_WAIT_FALL) begin
               pulse_width_in = width_new;
               scaled_in      = SCALE_W'({{(SCALE_W-CAP_W){1'b0}}, width_new} * SOUND_MUL)
                                + ROUND_ADD;
               phase_in       = PH_READY;
            end
         end
         OP_TAKE: begin
            if (phase_ff == PH_READY) begin
               phase_in = PH_IDLE;
               if (in_range) begin
                  rsp_in.distance_valid = 1'b1;
                  rsp_in.range_mm       = range_calc;
               end else begin
                  timeout_flag_in = 1'b1;
               end
            end
         end
         OP_READ: begin
            rsp_in.timed_out = timeout_flag_ff;
            timeout_flag_in  = 1'b0;
         end
         default: ;
      endcase
      rsp_in.busy_res = (phase_in == PH_WAIT_RISE) || (phase_in == PH_WAIT_FALL);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         timeout_flag_ff <= 1'b0;
         rise_time_ff    <= '0;
         pulse_width_ff  <= '0;
         scaled_ff       <= ROUND_ADD;
         start_time_ff   <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         timeout_flag_ff <= timeout_flag_in;
         rise_time_ff    <= rise_time_in;
         pulse_width_ff  <= pulse_width_in;
         scaled_ff       <= scaled_in;
         start_time_ff   <= start_time_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // result beat
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.accepted       = rsp_ff.accepted;
   assign rsp_chan.busy_res       = rsp_ff.busy_res;
   assign rsp_chan.distance_valid = rsp_ff.distance_valid;
   assign rsp_chan.range_mm       = rsp_ff.range_mm;
   assign rsp_chan.timed_out      = rsp_ff.timed_out;

   // a waiting command is never dropped while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !advance |=> stg_valid_ff && $stable(stg_op_ff))
      else $error("input stage lost a command under stall");

   // a started measurement reports busy in its own result
   assert property (@(posedge clock) disable iff (reset)
      fire && rsp_in.accepted |=> out_valid_ff && rsp_ff.busy_res &&
                                  (phase_ff == PH_WAIT_RISE))
      else $error("start accepted without entering wait-rise");

   // a take in ready always returns to idle and either reports or flags
   assert property (@(posedge clock) disable iff (reset)
      fire && stg_op_ff == OP_TAKE && phase_ff == PH_READY |=>
         phase_ff == PH_IDLE && (rsp_ff.distance_valid || timeout_flag_ff))
      else $error("take from ready did not complete");

   // distance only ever comes from a take
   assert property (@(posedge clock) disable iff (reset)
      fire && stg_op_ff != OP_TAKE |=> !rsp_ff.distance_valid && rsp_ff.range_mm == '0)
      else $error("distance reported outside a take");

   // an expired poll of a waiting measurement abandons it
   assert property (@(posedge clock) disable iff (reset)
      fire && stg_op_ff == OP_POLL && expired &&
      (phase_ff == PH_WAIT_RISE || phase_ff == PH_WAIT_FALL) |=>
         phase_ff == PH_IDLE && timeout_flag_ff && !rsp_ff.busy_res)
      else $error("expired poll did not time out the measurement");

endmodule

[test/echo_pulse_range_meter_tb.sv]
module echo_pulse_range_meter_tb import epr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES  = 3000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int RANDOM_PER_PHASE = 120;

   // ops that the block has to ignore
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;

   // register slot past the end of the map
   localparam logic [REG_IW-1:0] REG_SPARE = 2'd3;

   // distance scaling: mm = (w*343 + 1000) / 2000
   localparam int SOUND_MM_PER_US2K = 343;
   localparam int ROUND_HALF        = 1000;
   localparam int SCALE_DEN         = 2000;

   // result beats that can be read straight off the spec
   localparam rsp_type QUIET     = '0;
   localparam rsp_type ARMED     = '{accepted: 1'b1, busy_res: 1'b1, default: '0};
   localparam rsp_type BUSY_ONLY = '{busy_res: 1'b1, default: '0};
   localparam rsp_type FLAG_SET  = '{timed_out: 1'b1, default: '0};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] stamp;
      logic [CAP_W-1:0]  cap;
      logic              pinned;
      rsp_type           reading;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   epr_req_if req_chan ();
   epr_rsp_if rsp_chan ();

   echo_pulse_range_meter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow copy of the ranging state
   phase_type         meas_phase;
   logic [CAP_W-1:0]  rise_stamp;
   logic [CAP_W-1:0]  echo_width;
   logic              timeout_seen;
   logic [TIME_W-1:0] start_stamp;
   cfg_type           limits;

   rsp_type awaited_readings [$];
   int      mismatches = 0;
   int      cmds_issued = 0;
   bit      sender_eager = 1'b0;
   int      long_holds_asked = 0;
   int      long_holds_done = 0;

   // start, poll, edges, take and read; widths at min and above max, wrapped elapsed time included
   directed_row_type directed_rows [25] = '{
      '{OP_READ,    32'h0000_0000, 16'h0000, 1'b1, QUIET},
      '{OP_TAKE,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, QUIET},
      '{OP_CAPTURE, 32'h0000_0000, 16'hFFFF, 1'b1, QUIET},
      '{OP_POLL,    32'hFFFF_FFFF, 16'h0000, 1'b1, QUIET},
      '{OP_SPARE_5, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, QUIET},
      '{OP_START,   32'hFFFF_FFF0, 16'h0000, 1'b1, ARMED},
      '{OP_START,   32'h0000_0000, 16'h0000, 1'b1, BUSY_ONLY},
      '{OP_POLL,    32'h0000_0016, 16'h0000, 1'b0, QUIET},
      '{OP_SPARE_6, 32'h0000_0000, 16'h0000, 1'b1, BUSY_ONLY},
      '{OP_CAPTURE, 32'h0000_0000, 16'hFFF0, 1'b0, QUIET},
      '{OP_START,   32'h0000_0000, 16'h0000, 1'b1, BUSY_ONLY},
      '{OP_CAPTURE, 32'h0000_0000, 16'h0064, 1'b0, QUIET},
      '{OP_POLL,    32'hFFFF_FFFF, 16'h0000, 1'b0, QUIET},
      '{OP_START,   32'h0000_0000, 16'h0000, 1'b1, QUIET},
      '{OP_TAKE,    32'h0000_0000, 16'h0000, 1'b0, QUIET},
      '{OP_READ,    32'h0000_0000, 16'h0000, 1'b1, QUIET},
      '{OP_START,   32'h1234_5678, 16'hFFFF, 1'b1, ARMED},
      '{OP_CAPTURE, 32'h0000_0000, 16'h0000, 1'b0, QUIET},
      '{OP_CAPTURE, 32'h0000_0000, 16'd26241, 1'b0, QUIET},
      '{OP_TAKE,    32'h0000_0000, 16'h0000, 1'b1, QUIET},
      '{OP_READ,    32'h0000_0000, 16'h0000, 1'b1, FLAG_SET},
      '{OP_START,   32'hFFFF_FFFF, 16'h0000, 1'b1, ARMED},
      '{OP_POLL,    32'h0000_0027, 16'h0000, 1'b0, QUIET},
      '{OP_READ,    32'h0000_0000, 16'h0000, 1'b1, FLAG_SET},
      '{OP_READ,    32'h0000_0000, 16'h0000, 1'b1, QUIET}
   };

   // one command through the shadow state, returns its result beat
   function automatic rsp_type advance_ranging(input logic [OP_W-1:0] op,
                                               input logic [TIME_W-1:0] now,
                                               input logic [CAP_W-1:0] cap);
      rsp_type           r;
      logic [TIME_W-1:0] elapsed;
      int unsigned       scaled;
      r = '0;
      elapsed = now - start_stamp;
      case (op)
         OP_START: begin
            if (meas_phase == PH_IDLE) begin
               timeout_seen = 1'b0;
               echo_width = '0;
               start_stamp = now;
               meas_phase = PH_WAIT_RISE;
               r.accepted = 1'b1;
            end
         end
         OP_POLL: begin
            if ((meas_phase == PH_WAIT_RISE || meas_phase == PH_WAIT_FALL) &&
                elapsed >= TIME_W'(limits.timeout_ms)) begin
               meas_phase = PH_IDLE;
               timeout_seen = 1'b1;
            end
         end
         OP_CAPTURE: begin
            if (meas_phase == PH_WAIT_RISE) begin
               rise_stamp = cap;
               meas_phase = PH_WAIT_FALL;
            end else if (meas_phase == PH_WAIT_FALL) begin
               echo_width = cap - rise_stamp;
               meas_phase = PH_READY;
            end
         end
         OP_TAKE: begin
            if (meas_phase == PH_READY) begin
               meas_phase = PH_IDLE;
               if (echo_width < limits.min_pulse_us || echo_width > limits.max_pulse_us) begin
                  timeout_seen = 1'b1;
               end else begin
                  scaled = (int'(echo_width) * SOUND_MM_PER_US2K + ROUND_HALF) / SCALE_DEN;
                  r.distance_valid = 1'b1;
                  r.range_mm = scaled[DIST_W-1:0];
               end
            end
         end
         OP_READ: begin
            r.timed_out = timeout_seen;
            timeout_seen = 1'b0;
         end
         default: ;
      endcase
      r.busy_res = (meas_phase == PH_WAIT_RISE || meas_phase == PH_WAIT_FALL);
      return r;
   endfunction

   // idle length: mostly none, sometimes short, rarely long
   function automatic int pick_gap(input bit eager);
      if (eager) return 0;
      case ($urandom_range(0, 9))
         6, 7:    return $urandom_range(1, 3);
         8:       return $urandom_range(4, 12);
         9:       return $urandom_range(20, 60);
         default: return 0;
      endcase
   endfunction

   // echo width around the configured window
   function automatic logic [CAP_W-1:0] pick_width();
      case ($urandom_range(0, 7))
         0: return limits.min_pulse_us - 1'b1;
         1: return limits.min_pulse_us;
         2: return limits.max_pulse_us;
         3: return limits.max_pulse_us + 1'b1;
         4: return CAP_W'($urandom);
         default: begin
            if (limits.min_pulse_us <= limits.max_pulse_us)
               return CAP_W'($urandom_range(limits.min_pulse_us, limits.max_pulse_us));
            return CAP_W'($urandom);
         end
      endcase
   endfunction

   // offer one command beat, predict it on acceptance
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic [CAP_W-1:0] cap, input logic pinned,
                           input rsp_type pinned_reading);
      rsp_type predicted;
      int      gap;
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.time_ms <= now;
      req_chan.capture_value <= cap;
      do @(posedge clock); while (!req_chan.ready);
      predicted = advance_ranging(op, now, cap);
      awaited_readings.push_back(pinned ? pinned_reading : predicted);
      if (op <= OP_READ) cmds_issued++;
      @(negedge clock);
      gap = pick_gap(sender_eager);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold the sender until every result beat is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (awaited_readings.size() != 0) @(negedge clock);
   endtask

   // apb write: setup then access
   task automatic csr_write(input logic [REG_IW-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= {16'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TIMEOUT:   limits.timeout_ms = value;
         REG_MIN_PULSE: limits.min_pulse_us = value;
         REG_MAX_PULSE: limits.max_pulse_us = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_limits(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] hi, input bit poke_spare);
      drain();
      csr_write(REG_TIMEOUT, tmo);
      csr_write(REG_MIN_PULSE, lo);
      csr_write(REG_MAX_PULSE, hi);
      if (poke_spare) csr_write(REG_SPARE, CFG_W'($urandom));
   endtask

   // poll now and then, mostly before the limit
   task automatic maybe_poll(input logic [TIME_W-1:0] t0);
      logic [TIME_W-1:0] delta;
      if ($urandom_range(0, 2) != 0) return;
      case ($urandom_range(0, 5))
         0: delta = TIME_W'(limits.timeout_ms);
         1: delta = TIME_W'(limits.timeout_ms) - 1'b1;
         2: delta = $urandom;
         default: begin
            if (limits.timeout_ms == 0) delta = '0;
            else delta = TIME_W'($urandom_range(0, limits.timeout_ms - 1));
         end
      endcase
      send_cmd(OP_POLL, t0 + delta, CAP_W'($urandom), 1'b0, QUIET);
   endtask

   // full start / rise / fall / take sequence with random content
   task automatic run_measurement();
      logic [TIME_W-1:0] t0;
      logic [CAP_W-1:0]  rise;
      if ($urandom_range(0, 3) == 0) t0 = 32'hFFFF_FFFF - $urandom_range(0, 100);
      else t0 = $urandom;
      send_cmd(OP_START, t0, CAP_W'($urandom), 1'b0, QUIET);
      maybe_poll(t0);
      rise = CAP_W'($urandom);
      send_cmd(OP_CAPTURE, $urandom, rise, 1'b0, QUIET);
      maybe_poll(t0);
      send_cmd(OP_CAPTURE, $urandom, rise + pick_width(), 1'b0, QUIET);
      maybe_poll(t0);
      send_cmd(OP_TAKE, $urandom, CAP_W'($urandom), 1'b0, QUIET);
      if ($urandom_range(0, 1) == 0) send_cmd(OP_READ, $urandom, CAP_W'($urandom), 1'b0, QUIET);
   endtask

   // mostly good sequences, some stray commands
   task automatic random_phase(input int count);
      int target;
      int n;
      target = cmds_issued + count;
      while (cmds_issued < target) begin
         sender_eager = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 39) == 0) drain();
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) send_cmd(OP_W'($urandom_range(0, 7)), $urandom, CAP_W'($urandom),
                                1'b0, QUIET);
         end else begin
            run_measurement();
         end
      end
   endtask

   // result channel back-pressure
   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = pick_gap($urandom_range(0, 5) == 0);
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   // compare each result beat with the oldest prediction
   // fields printed as accepted/busy/valid/mm/timed_out
   always @(posedge clock) begin : reading_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{accepted: rsp_chan.accepted, busy_res: rsp_chan.busy_res,
                 distance_valid: rsp_chan.distance_valid,
                 range_mm: rsp_chan.range_mm, timed_out: rsp_chan.timed_out};
         if (awaited_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing outstanding: %0b/%0b/%0b/%0d/%0b",
                        $realtime, got.accepted, got.busy_res, got.distance_valid,
                        got.range_mm, got.timed_out);
         end else begin
            want = awaited_readings.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: exp %0b/%0b/%0b/%0d/%0b got %0b/%0b/%0b/%0d/%0b",
                           $realtime, want.accepted, want.busy_res, want.distance_valid,
                           want.range_mm, want.timed_out, got.accepted, got.busy_res,
                           got.distance_valid, got.range_mm, got.timed_out);
            end
         end
      end
   end

   // stop a hung run
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int               row;
      logic [CFG_W-1:0] lo_pick;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_START;
      req_chan.time_ms = '0;
      req_chan.capture_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      meas_phase = PH_IDLE;
      rise_stamp = '0;
      echo_width = '0;
      timeout_seen = 1'b0;
      start_stamp = '0;
      limits = '{timeout_ms: TIMEOUT_RST, min_pulse_us: MIN_PULSE_RST,
                 max_pulse_us: MAX_PULSE_RST};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at reset limits
      for (row = 0; row < 25; row++)
         send_cmd(directed_rows[row].op, directed_rows[row].stamp, directed_rows[row].cap,
                  directed_rows[row].pinned, directed_rows[row].reading);

      // reset limits, receiver holds off long at the start
      long_holds_asked++;
      random_phase(RANDOM_PER_PHASE);

      // zero timeout, widest window, stray register write
      apply_limits(16'd0, 16'd0, 16'hFFFF, 1'b1);
      random_phase(RANDOM_PER_PHASE);

      // longest timeout, only the top width passes
      apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      random_phase(RANDOM_PER_PHASE);

      // min above max: every width fails
      apply_limits(16'd1, 16'd30000, 16'd200, 1'b0);
      random_phase(RANDOM_PER_PHASE);

      // random limits, another long hold-off
      lo_pick = CFG_W'($urandom_range(0, 2000));
      apply_limits(CFG_W'($urandom_range(1, 300)), lo_pick,
                   CFG_W'($urandom_range(20000, 65535)), 1'b1);
      long_holds_asked++;
      random_phase(RANDOM_PER_PHASE);

      drain();
      repeat (4) @(negedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
rtl/core/epr_pkg.sv
rtl/core/epr_if.sv
rtl/core/epr_csr.sv
rtl/core/echo_pulse_range_meter.sv
test/echo_pulse_range_meter_tb.sv
